/* rtl/pulse_rate_monitor_assert.svh */
// Assertion macros shared by the pulse rate monitor modules.
`ifndef PULSE_RATE_MONITOR_ASSERT_SVH
`define PULSE_RATE_MONITOR_ASSERT_SVH

// The property is checked on every clock edge and is not checked while reset is applied.
`define PRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The property is checked on every clock edge, including the edges that fall during reset.
`define PRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/prm_pkg.sv */
// Types and constants shared by the pulse rate monitor modules.
`default_nettype none

package prm_pkg;

  localparam int unsigned RATE_W  = 16;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned QCNT_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_LIMIT   = 2'd0,
    CFG_LOWER_LIMIT   = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_idx_e;

  localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST   = 8'd100;
  localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RST   = 8'd40;
  localparam logic [RATE_W-1:0]  TIMEOUT_TICKS_RST = 16'd5000;

  typedef struct packed {
    logic func;
    logic pulse_level;
  } in_word_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_bpm;
    logic              rate_new;
    logic              alarm;
    logic              no_pulse;
    logic              display_update;
  } out_word_t;

  typedef struct packed {
    logic sample;
    logic level;
  } qual_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

/* rtl/prm_qual.sv */
// Pulse qualifier: counts consecutive low pin samples and confirms a pulse on the next high one.
`default_nettype none

module prm_qual #(
  parameter int unsigned QUALIFY_SAMPLES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire prm_pkg::qual_ctrl_t ctrl_i,
  output logic                     confirm_o
);

  localparam logic [prm_pkg::QCNT_W-1:0] QS = prm_pkg::QCNT_W'(QUALIFY_SAMPLES);

  logic [prm_pkg::QCNT_W-1:0] count_q, count_d;
  logic                       full;

  assign full      = (count_q >= QS);
  assign confirm_o = ctrl_i.sample && full && ctrl_i.level;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.sample) begin
      if (full) begin
        // Once full, further low samples hold the count until a high one arrives.
        if (ctrl_i.level) begin
          count_d = '0;
        end
      end else if (!ctrl_i.level) begin
        count_d = count_q + 1'b1;
      end else begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/prm_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

`include "pulse_rate_monitor_assert.svh"

module prm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire prm_pkg::div_req_t            req_i,
  output logic                              busy_o,
  output logic [prm_pkg::RATE_W-1:0]        quotient_o
);

  localparam int unsigned W   = prm_pkg::RATE_W;
  localparam int unsigned CW  = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // The partial remainder picks up the next dividend bit from the top of the quotient register.
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[W-2:0], fits};
      rem_d = fits ? diff[W-1:0] : shifted[W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  `PRM_ASSERT(a_div_no_restart, req_i.start |-> !busy_q, "divider started while busy")
  `PRM_ASSERT(a_div_full_length, $fell(busy_q) |-> $past(cnt_q) == LAST,
              "divider finished before all quotient bits")
  `PRM_ASSERT(a_div_nonzero, req_i.start |-> req_i.divisor != '0, "divider started with zero")

endmodule

`default_nettype wire

/* rtl/pulse_rate_monitor.sv */
// Pulse rate meter top level: sample and tick handling, limits, alarm and result register.
`default_nettype none

`include "pulse_rate_monitor_assert.svh"

// Each accepted word is a 1 ms count tick or a 10 ms pin sample and produces exactly one
// result word. Ticks and samples that do not complete a pulse interval are handled in the
// idle state. The sample that confirms the second pulse starts a bit-serial divide of
// TICKS_PER_MINUTE by the interval: the divider works out the 16 quotient bits in turn,
// then the rate, alarm and flags go into the result register once it is free; no word is
// taken until then. A new word is taken in the idle state while the result register is
// empty or is being taken in the same cycle. Limit and timeout registers are written
// through cfg_we_i, cfg_idx_i and cfg_wdata_i while the block is idle: a rule for the
// user, not enforced by the block. Indexes beyond the timeout register are ignored.
module pulse_rate_monitor #(
  parameter int unsigned TICKS_PER_MINUTE = 60000,
  parameter int unsigned QUALIFY_SAMPLES  = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [prm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [prm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire prm_pkg::in_word_t                   in_word_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output prm_pkg::out_word_t                       out_word_o
);

  localparam int unsigned RW = prm_pkg::RATE_W;
  localparam logic [RW-1:0] TPM = RW'(TICKS_PER_MINUTE);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [prm_pkg::LIMIT_W-1:0]   upper_q, lower_q;
  logic [RW-1:0]                 timeout_q;
  logic [RW-1:0]                 ic_q, ic_d;
  logic                          armed_q, armed_d;
  logic                          stopped_q, stopped_d;
  logic                          alarm_q, alarm_d;
  logic [RW-1:0]                 rate_q, rate_d;
  logic                          out_valid_q, out_valid_d;
  prm_pkg::out_word_t            out_q, out_d;
  logic                          out_load;

  logic                          accept;
  logic                          out_free;
  logic                          confirm;
  logic                          div_busy;
  logic [RW-1:0]                 quotient;
  logic [RW-1:0]                 ic_inc;
  logic                          rate_alarm;
  prm_pkg::qual_ctrl_t           qual_ctrl;
  prm_pkg::div_req_t             div_req;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign qual_ctrl.sample = accept && in_word_i.func;
  assign qual_ctrl.level  = in_word_i.pulse_level;

  prm_qual #(
    .QUALIFY_SAMPLES(QUALIFY_SAMPLES)
  ) u_qual (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (qual_ctrl),
    .confirm_o(confirm)
  );

  // The second confirmed pulse divides; an interval of zero counts as one tick.
  assign div_req.start    = confirm && armed_q;
  assign div_req.dividend = TPM;
  assign div_req.divisor  = (ic_q == '0) ? RW'(1) : ic_q;

  prm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

  assign ic_inc     = ic_q + 1'b1;
  assign rate_alarm = (quotient >= RW'(upper_q)) || (quotient <= RW'(lower_q));

  always_comb begin
    state_d   = state_q;
    ic_d      = ic_q;
    armed_d   = armed_q;
    stopped_d = stopped_q;
    alarm_d   = alarm_q;
    rate_d    = rate_q;
    out_load  = 1'b0;
    out_d     = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.display_update = 1'b0;
          out_d.rate_new       = 1'b0;
          if (in_word_i.func) begin
            if (confirm) begin
              ic_d = '0;
              if (armed_q) begin
                armed_d   = 1'b0;
                stopped_d = 1'b0;
                state_d   = ST_DIV;
              end else begin
                armed_d = 1'b1;
              end
            end
          end else begin
            ic_d = ic_inc;
            if (ic_inc == timeout_q) begin
              ic_d                 = '0;
              armed_d              = 1'b0;
              stopped_d            = 1'b1;
              alarm_d              = 1'b0;
              out_d.display_update = 1'b1;
            end
          end
          out_d.rate_bpm = rate_q;
          out_d.alarm    = alarm_d;
          out_d.no_pulse = stopped_d;
          out_load       = !div_req.start;
        end
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          rate_d               = quotient;
          alarm_d              = rate_alarm;
          out_d.rate_bpm       = quotient;
          out_d.rate_new       = 1'b1;
          out_d.alarm          = rate_alarm;
          out_d.no_pulse       = 1'b0;
          out_d.display_update = 1'b1;
          out_load             = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ic_q        <= '0;
      armed_q     <= 1'b0;
      stopped_q   <= 1'b0;
      alarm_q     <= 1'b0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ic_q        <= ic_d;
      armed_q     <= armed_d;
      stopped_q   <= stopped_d;
      alarm_q     <= alarm_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= prm_pkg::UPPER_LIMIT_RST;
      lower_q   <= prm_pkg::LOWER_LIMIT_RST;
      timeout_q <= prm_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prm_pkg::CFG_UPPER_LIMIT:   upper_q   <= cfg_wdata_i[prm_pkg::LIMIT_W-1:0];
        prm_pkg::CFG_LOWER_LIMIT:   lower_q   <= cfg_wdata_i[prm_pkg::LIMIT_W-1:0];
        prm_pkg::CFG_TIMEOUT_TICKS: timeout_q <= cfg_wdata_i[RW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `PRM_ASSERT_ALWAYS(a_div_blocks_input, (state_q == ST_DIV) |-> in_stall_o,
                     "word accepted during divide")
  `PRM_ASSERT(a_rate_new_flags, (out_valid_q && out_q.rate_new) |->
              (out_q.display_update && !out_q.no_pulse), "new rate without update flags")
  `PRM_ASSERT(a_div_start_enters_div, div_req.start |=> (state_q == ST_DIV),
              "divide started without entering divide state")

endmodule

`default_nettype wire

/* verif/pulse_rate_monitor_tb.sv */
// Self-checking testbench for the pulse rate monitor: random and directed words, scoreboard.
`timescale 1ns / 1ps

module pulse_rate_monitor_tb;

  localparam int unsigned TICKS_PER_MINUTE = 60000;
  localparam int unsigned QUALIFY_SAMPLES  = 4;
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned PHASE_QUOTA   = 115;

  class rate_scoreboard;
    logic [prm_pkg::LIMIT_W-1:0] upper_lim;
    logic [prm_pkg::LIMIT_W-1:0] lower_lim;
    logic [prm_pkg::RATE_W-1:0]  timeout_lim;
    logic [prm_pkg::QCNT_W-1:0]  low_run;
    logic [prm_pkg::RATE_W-1:0]  interval_ms;
    logic [prm_pkg::RATE_W-1:0]  last_rate;
    bit                          armed;
    bit                          stopped;
    bit                          alarm_on;
    prm_pkg::out_word_t          expected_readings[$];
    int unsigned                 fail_count;

    function new();
      upper_lim   = prm_pkg::UPPER_LIMIT_RST;
      lower_lim   = prm_pkg::LOWER_LIMIT_RST;
      timeout_lim = prm_pkg::TIMEOUT_TICKS_RST;
      low_run     = '0;
      interval_ms = '0;
      last_rate   = '0;
      armed       = 1'b0;
      stopped     = 1'b0;
      alarm_on    = 1'b0;
      fail_count  = 0;
    endfunction

    function void write_reg(prm_pkg::cfg_idx_e idx, logic [prm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        prm_pkg::CFG_UPPER_LIMIT:   upper_lim = val[prm_pkg::LIMIT_W-1:0];
        prm_pkg::CFG_LOWER_LIMIT:   lower_lim = val[prm_pkg::LIMIT_W-1:0];
        prm_pkg::CFG_TIMEOUT_TICKS: timeout_lim = val;
        default: ;
      endcase
    endfunction

    // Advances the meter by one accepted word and queues the reading it produces.
    function void note_word(prm_pkg::in_word_t w);
      prm_pkg::out_word_t rd;
      int unsigned        divisor;
      int unsigned        rate;
      rd = '0;
      if (w.func == FUNC_SAMPLE) begin
        if (low_run >= QUALIFY_SAMPLES) begin
          if (w.pulse_level) begin
            if (armed) begin
              divisor   = (interval_ms == 0) ? 1 : interval_ms;
              rate      = TICKS_PER_MINUTE / divisor;
              last_rate = rate[prm_pkg::RATE_W-1:0];
              alarm_on  = (last_rate >= upper_lim) || (last_rate <= lower_lim);
              rd.rate_new       = 1'b1;
              rd.display_update = 1'b1;
              armed   = 1'b0;
              stopped = 1'b0;
            end else begin
              armed = 1'b1;
            end
            interval_ms = '0;
            low_run     = '0;
          end
        end else if (!w.pulse_level) begin
          low_run = low_run + 1'b1;
        end else begin
          low_run = '0;
        end
      end else begin
        interval_ms = interval_ms + 1'b1;
        if (interval_ms == timeout_lim) begin
          interval_ms       = '0;
          rd.display_update = 1'b1;
          armed    = 1'b0;
          stopped  = 1'b1;
          alarm_on = 1'b0;
        end
      end
      rd.rate_bpm = last_rate;
      rd.alarm    = alarm_on;
      rd.no_pulse = stopped;
      expected_readings.push_back(rd);
    endfunction

    function void check_word(prm_pkg::out_word_t got);
      prm_pkg::out_word_t exp_rd;
      if (expected_readings.size() == 0) begin
        if (fail_count < 10) $display("unexpected reading: got %p", got);
        fail_count++;
      end else begin
        exp_rd = expected_readings.pop_front();
        if (got.rate_bpm !== exp_rd.rate_bpm || got.rate_new !== exp_rd.rate_new ||
            got.alarm !== exp_rd.alarm || got.no_pulse !== exp_rd.no_pulse ||
            got.display_update !== exp_rd.display_update) begin
          if (fail_count < 10) begin
            $display("reading mismatch at %0t: expected %p, got %p", $realtime, exp_rd, got);
          end
          fail_count++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  prm_pkg::cfg_idx_e              cfg_idx;
  logic [prm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  prm_pkg::in_word_t              in_word;
  logic                           out_valid;
  logic                           out_stall;
  prm_pkg::out_word_t             out_word;

  rate_scoreboard sb;
  int unsigned    send_gap_pct;
  int unsigned    recv_stall_pct;
  int unsigned    words_sent;
  int unsigned    hold_left;
  int unsigned    cycles;
  bit             hold_req;

  pulse_rate_monitor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (out_valid && !out_stall) sb.check_word(out_word);
    end
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_item(logic func, logic level);
    prm_pkg::in_word_t w;
    w.func        = func;
    w.pulse_level = level;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  task automatic send_ticks(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(FUNC_TICK, 1'($urandom_range(1)));
  endtask

  task automatic send_pulse();
    repeat (QUALIFY_SAMPLES) send_item(FUNC_SAMPLE, 1'b0);
    send_item(FUNC_SAMPLE, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_setting(prm_pkg::cfg_idx_e idx, logic [prm_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_phase(int unsigned p);
    case (p % 4)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
      default: begin send_gap_pct = 11; recv_stall_pct = 11; end
    endcase
    case (p)
      0: begin
        write_setting(prm_pkg::CFG_UPPER_LIMIT, 16'd150);
        write_setting(prm_pkg::CFG_LOWER_LIMIT, 16'd30);
        write_setting(prm_pkg::CFG_TIMEOUT_TICKS, 16'd5000);
      end
      1: begin
        // Inverted limits and a timeout on every tick.
        write_setting(prm_pkg::CFG_UPPER_LIMIT, 16'd31);
        write_setting(prm_pkg::CFG_LOWER_LIMIT, 16'd149);
        write_setting(prm_pkg::CFG_TIMEOUT_TICKS, 16'd1);
      end
      2: begin
        // The upper byte of a limit write is dropped; limits are used unchecked.
        write_setting(prm_pkg::CFG_UPPER_LIMIT, 16'hff00 | 16'd200);
        write_setting(prm_pkg::CFG_LOWER_LIMIT, 16'hab00);
        write_setting(prm_pkg::CFG_TIMEOUT_TICKS, 16'hffff);
      end
      default: begin
        write_setting(prm_pkg::CFG_UPPER_LIMIT, 16'($urandom_range(150, 31)));
        write_setting(prm_pkg::CFG_LOWER_LIMIT, 16'($urandom_range(149, 30)));
        if ($urandom_range(1)) begin
          write_setting(prm_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(60, 10)));
        end else begin
          write_setting(prm_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(3000, 300)));
        end
      end
    endcase
  endtask

  // Mostly well-formed pulses with random spacing, some broken runs and noise.
  task automatic run_random(int unsigned quota);
    int unsigned target;
    int unsigned lows;
    int unsigned gap;
    int unsigned lim;
    int unsigned pick;
    target = words_sent + quota;
    while (words_sent < target) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(9) < 8) lows = QUALIFY_SAMPLES + $urandom_range(2);
        else lows = $urandom_range(QUALIFY_SAMPLES - 1, 1);
        for (int unsigned i = 0; i < lows; i++) begin
          if ($urandom_range(9) == 0) send_item(FUNC_TICK, 1'($urandom_range(1)));
          send_item(FUNC_SAMPLE, 1'b0);
        end
        send_item(FUNC_SAMPLE, 1'b1);
        pick = $urandom_range(99);
        if (pick < 4) begin
          gap = 0;
        end else if (pick < 92) begin
          gap = $urandom_range(30, 1);
        end else begin
          // Space the pulses so the rate lands on or next to a limit, when that fits.
          lim = $urandom_range(1) ? sb.upper_lim : sb.lower_lim;
          gap = (lim == 0) ? 400 : TICKS_PER_MINUTE / lim + $urandom_range(2) - 1;
          if (words_sent + gap > target) gap = $urandom_range(30, 1);
        end
        send_ticks(gap);
      end else begin
        repeat ($urandom_range(6, 1)) send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = prm_pkg::CFG_UPPER_LIMIT;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_word        = '0;
    hold_req       = 1'b0;
    words_sent     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ticks with both pin levels, a qualifier restart, lows held at full count,
    // then a second pulse with no ticks in between for a zero interval.
    send_item(FUNC_TICK, 1'b0);
    send_item(FUNC_TICK, 1'b1);
    send_item(FUNC_SAMPLE, 1'b1);
    repeat (3) send_item(FUNC_SAMPLE, 1'b0);
    send_item(FUNC_SAMPLE, 1'b1);
    repeat (QUALIFY_SAMPLES + 1) send_item(FUNC_SAMPLE, 1'b0);
    send_item(FUNC_SAMPLE, 1'b1);
    repeat (QUALIFY_SAMPLES) send_item(FUNC_SAMPLE, 1'b0);
    send_item(FUNC_SAMPLE, 1'b1);
    send_ticks(3);
    drain();

    // A timeout of zero does not fire before the interval counter wraps.
    write_setting(prm_pkg::CFG_TIMEOUT_TICKS, 16'd0);
    send_ticks(40);
    drain();

    // Limits near the top of the byte range put rates on and between both limits
    // with short intervals: 255 hits the upper limit, 254 is clear, 250 hits the lower.
    write_setting(prm_pkg::CFG_UPPER_LIMIT, 16'd255);
    write_setting(prm_pkg::CFG_LOWER_LIMIT, 16'd250);
    write_setting(prm_pkg::CFG_TIMEOUT_TICKS, 16'hffff);
    send_pulse();
    send_ticks(235);
    send_pulse();
    send_pulse();
    send_ticks(236);
    send_pulse();
    send_pulse();
    send_ticks(240);
    send_pulse();
    drain();

    for (int unsigned p = 0; p < 8; p++) begin
      apply_phase(p);
      if (p == 0) hold_req = 1'b1;
      run_random(PHASE_QUOTA);
      drain();
    end

    if (sb.fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
